FILE: rtl/core/tsc_pkg.sv
package tsc_pkg;

  typedef enum logic [2:0] {
    KIND_ACTIVATE  = 3'd0,
    KIND_TICK      = 3'd1,
    KIND_PACKET    = 3'd2,
    KIND_LINK_UP   = 3'd3,
    KIND_LINK_DOWN = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ACT_HANDSHAKE = 2'd0,
    ACT_HEARTBEAT = 2'd1,
    ACT_ECHO      = 2'd2,
    ACT_SENSOR    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_COOLDOWN  = 3'd0,
    REG_TIMEOUT   = 3'd1,
    REG_HEARTBEAT = 3'd2,
    REG_RETRY     = 3'd3,
    REG_STAGGER   = 3'd4,
    REG_PERIOD    = 3'd5,
    REG_HUB       = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_EMIT  = 2'd2
  } back_state_t;

  localparam logic [31:0] PTYPE_ECHO      = 32'd10;
  localparam logic [31:0] PTYPE_HEARTBEAT = 32'd1;
  localparam logic [31:0] PTYPE_HANDSHAKE = 32'd3;
  localparam logic [7:0]  FBYTE_HANDSHAKE = 8'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  tracker;
    logic [31:0] now_ms;
    logic        is_echo;
    logic        is_hb;
    logic        is_hs;
  } evt_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  tracker;
    logic [31:0] packet_number;
    logic        reset_socket;
    logic        to_broadcast;
    logic        server_known;
    logic        last;
  } res_t;

endpackage

FILE: rtl/core/tsc_front.sv
module tsc_front #(
  parameter int NUM_TRACKERS = 16,
  parameter int QDEPTH       = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic [3:0]         in_tracker,
  input  logic [31:0]        in_now_ms,
  input  logic [31:0]        in_packet_type,
  input  logic [7:0]         in_first_byte,
  input  logic               in_signature_found,
  input  logic [31:0]        in_remote_addr,
  output logic               q_valid,
  output tsc_pkg::evt_t      q_evt,
  output logic [31:0]        q_addr,
  input  logic               q_take
);
  import tsc_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  evt_t        evt_r  [QDEPTH];
  logic [31:0] addr_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  evt_t        cls;
  logic        push, keep;

  always_comb begin
    cls.kind    = in_kind;
    cls.tracker = in_tracker;
    cls.now_ms  = in_now_ms;
    cls.is_echo = (in_packet_type == PTYPE_ECHO);
    cls.is_hb   = (in_packet_type == PTYPE_HEARTBEAT);
    cls.is_hs   = (in_packet_type == PTYPE_HANDSHAKE || in_first_byte == FBYTE_HANDSHAKE)
                  && in_signature_found;
  end

  // Events that can never change state are dropped here.
  assign keep = (in_kind <= 3'(KIND_LINK_DOWN)) &&
                (in_kind == 3'(KIND_LINK_UP) || in_kind == 3'(KIND_LINK_DOWN) ||
                 32'(in_tracker) < NUM_TRACKERS);
  assign in_stall = (cnt_r == (PW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != '0);
  assign q_evt    = evt_r[rp_r];
  assign q_addr   = addr_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (q_take) rp_r <= (rp_r == PW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(q_take);
    end
    if (push) begin
      evt_r[wp_r]  <= cls;
      addr_r[wp_r] <= in_remote_addr;
    end
  end
endmodule

FILE: rtl/core/tsc_back.sv
module tsc_back #(
  parameter int NUM_TRACKERS = 16,
  parameter int TIME_BITS    = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  tsc_pkg::evt_t q_evt,
  input  logic [31:0]   q_addr,
  output logic          q_take,
  input  logic [19:0]   cooldown_ms,
  input  logic [19:0]   timeout_ms,
  input  logic [19:0]   heartbeat_ms,
  input  logic [19:0]   retry_base_ms,
  input  logic [7:0]    retry_stagger_ms,
  input  logic [3:0]    socket_reset_period,
  input  logic [3:0]    hub_index,
  output logic          out_valid,
  input  logic          out_stall,
  output tsc_pkg::res_t out_res
);
  import tsc_pkg::*;

  localparam int TW = $clog2(NUM_TRACKERS);
  localparam int TB = TIME_BITS;

  logic [NUM_TRACKERS-1:0] act_r, hs_r, init_r;
  logic [TB-1:0] lhs_r [NUM_TRACKERS];
  logic [TB-1:0] lrx_r [NUM_TRACKERS];
  logic [TB-1:0] lhb_r [NUM_TRACKERS];
  logic [TB-1:0] tmo_r [NUM_TRACKERS];
  logic [3:0]    ph_r  [NUM_TRACKERS];
  logic [31:0]   seq_r [NUM_TRACKERS];
  logic disc_r, gs_r;
  logic [31:0] srv_r;

  back_state_t st_r, st_nxt;
  evt_t        e_r;
  res_t        r0_r, r1_r;
  logic        has1_r;
  logic [20:0] interval_r;
  res_t        ob_r;
  logic        ob_v_r;
  logic        em_any_r;
  logic [31:0] q_addr_r;
  logic        ob_load;

  logic [TW-1:0] t;
  logic [TB-1:0] now;
  logic [TB-1:0] d_hs, d_rx, d_hb, d_to;
  logic [3:0]    ph_inc;
  logic [3:0]    per;

  assign t   = e_r.tracker[TW-1:0];
  assign now = e_r.now_ms[TB-1:0];
  assign d_hs = now - lhs_r[t];
  assign d_rx = now - lrx_r[t];
  assign d_hb = now - lhb_r[t];
  assign d_to = now - tmo_r[t];
  assign ph_inc = ph_r[t] + 4'd1;
  assign per = (socket_reset_period == 4'd0) ? 4'd1 : socket_reset_period;

  assign out_valid = ob_v_r;
  assign out_res   = ob_r;
  assign q_take    = (st_r == ST_IDLE) && q_valid;
  assign ob_load   = (st_r == ST_EMIT) && (!ob_v_r || !out_stall) && em_any_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_EXEC;
      ST_EXEC: st_nxt = ST_EMIT;
      ST_EMIT: if (!ob_v_r || !out_stall) begin
        if (!(r0_r.last || has1_r) || r0_r.last) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // EXEC does the read-modify-write and builds up to two results.
  always_ff @(posedge clk) begin
    logic        n0, n1;
    res_t        a0, a1;
    logic        hs_fire, cool, to_fire;
    logic [31:0] sq;
    logic        rst_sock;
    if (!rst_n) begin
      st_r <= ST_IDLE;
      act_r <= '0; hs_r <= '0; init_r <= '0;
      disc_r <= 1'b1; gs_r <= 1'b0; srv_r <= '0;
      ob_v_r <= 1'b0; has1_r <= 1'b0;
      r0_r <= '0;
      for (int i = 0; i < NUM_TRACKERS; i++) begin
        lhs_r[i] <= '0; lrx_r[i] <= '0; lhb_r[i] <= '0; tmo_r[i] <= '0;
        ph_r[i] <= '0; seq_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (ob_load) begin
        ob_r <= r0_r; ob_v_r <= 1'b1;
      end else if (ob_v_r && !out_stall) begin
        ob_v_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: if (q_valid) begin
          e_r <= q_evt;
          interval_r <= 21'(retry_base_ms) + 21'(q_evt.tracker) * 21'(retry_stagger_ms);
        end
        ST_EXEC: begin
          n0 = 1'b0; n1 = 1'b0; a0 = '0; a1 = '0;
          sq = seq_r[t];
          case (e_r.kind)
            3'(KIND_LINK_UP): begin
              gs_r <= 1'b0; disc_r <= 1'b1; srv_r <= '0;
              for (int i = 0; i < NUM_TRACKERS; i++) begin
                if (act_r[i] || 32'(hub_index) == i) begin
                  act_r[i] <= 1'b1;
                  lrx_r[i] <= now; lhb_r[i] <= now; ph_r[i] <= '0;
                  init_r[i] <= 1'b0; hs_r[i] <= 1'b1;
                  lhs_r[i] <= '0; seq_r[i] <= '0;
                end
              end
            end
            3'(KIND_LINK_DOWN): begin
              disc_r <= 1'b1; gs_r <= 1'b0; init_r <= '0; hs_r <= '0;
            end
            3'(KIND_ACTIVATE): if (!act_r[t]) begin
              act_r[t] <= 1'b1; hs_r[t] <= 1'b1; init_r[t] <= 1'b0;
              lhb_r[t] <= now; lhs_r[t] <= now; seq_r[t] <= 32'd1;
              n0 = 1'b1;
              a0 = '{action: ACT_HANDSHAKE, tracker: e_r.tracker, packet_number: 32'd0,
                     reset_socket: 1'b0, to_broadcast: disc_r, server_known: gs_r,
                     last: 1'b0};
            end
            3'(KIND_TICK): if (act_r[t]) begin
              cool = hs_r[t] && (tmo_r[t] != '0) && (32'(d_to) < 32'(cooldown_ms));
              if (!cool) begin
                hs_fire = hs_r[t] && (32'(d_hs) > 32'(interval_r));
                if (hs_fire) begin
                  rst_sock = (ph_inc >= per);
                  lhs_r[t] <= now;
                  ph_r[t] <= rst_sock ? 4'd0 : ph_inc;
                  n0 = 1'b1;
                  a0 = '{action: ACT_HANDSHAKE, tracker: e_r.tracker, packet_number: sq,
                         reset_socket: rst_sock, to_broadcast: disc_r,
                         server_known: gs_r, last: 1'b0};
                  sq = sq + 32'd1;
                end
                to_fire = init_r[t] && (32'(d_rx) > 32'(timeout_ms));
                if (to_fire) begin
                  init_r[t] <= 1'b0; hs_r[t] <= 1'b1; ph_r[t] <= '0;
                  lhs_r[t] <= '0; tmo_r[t] <= now;
                end else if (init_r[t] && e_r.tracker != hub_index &&
                             32'(d_hb) > 32'(heartbeat_ms)) begin
                  lhb_r[t] <= now;
                  if (n0) begin
                    n1 = 1'b1;
                    a1 = '{action: ACT_HEARTBEAT, tracker: e_r.tracker, packet_number: sq,
                           reset_socket: 1'b0, to_broadcast: 1'b0,
                           server_known: gs_r, last: 1'b0};
                  end else begin
                    n0 = 1'b1;
                    a0 = '{action: ACT_HEARTBEAT, tracker: e_r.tracker, packet_number: sq,
                           reset_socket: 1'b0, to_broadcast: 1'b0,
                           server_known: gs_r, last: 1'b0};
                  end
                  sq = sq + 32'd1;
                end
                seq_r[t] <= sq;
              end
            end
            3'(KIND_PACKET): if (act_r[t]) begin
              if (disc_r) begin
                srv_r <= q_addr_r; disc_r <= 1'b0; gs_r <= 1'b1;
              end
              lrx_r[t] <= now;
              if (e_r.is_echo) begin
                n0 = 1'b1;
                a0 = '{action: ACT_ECHO, tracker: e_r.tracker, packet_number: 32'd0,
                       reset_socket: 1'b0, to_broadcast: 1'b0,
                       server_known: gs_r | disc_r, last: 1'b0};
              end else if (e_r.is_hb) begin
                n0 = 1'b1;
                a0 = '{action: ACT_HEARTBEAT, tracker: e_r.tracker, packet_number: sq,
                       reset_socket: 1'b0, to_broadcast: 1'b0,
                       server_known: gs_r | disc_r, last: 1'b0};
                seq_r[t] <= sq + 32'd1;
              end else if (e_r.is_hs && hs_r[t]) begin
                hs_r[t] <= 1'b0; init_r[t] <= 1'b1; tmo_r[t] <= '0;
                // The success flag is already set here: either discovery has just
                // set it, or discovery had ended earlier, which also sets it.
                if (e_r.tracker == hub_index) begin
                  act_r[t] <= 1'b0;
                end else begin
                  n0 = 1'b1; n1 = 1'b1;
                  a0 = '{action: ACT_HANDSHAKE, tracker: e_r.tracker, packet_number: sq,
                         reset_socket: 1'b0, to_broadcast: 1'b0,
                         server_known: 1'b1, last: 1'b0};
                  a1 = '{action: ACT_SENSOR, tracker: e_r.tracker,
                         packet_number: sq + 32'd1, reset_socket: 1'b0,
                         to_broadcast: 1'b0, server_known: 1'b1, last: 1'b0};
                  seq_r[t] <= sq + 32'd2;
                end
              end
            end
            default: ;
          endcase
          // With no result, r0 is marked last so EMIT loads nothing and returns to IDLE.
          a0.last = !n1;
          a1.last = 1'b1;
          r0_r   <= a0;
          r1_r   <= a1;
          has1_r <= n1;
          em_any_r <= n0;
        end
        ST_EMIT: if (!ob_v_r || !out_stall) begin
          if (has1_r) begin
            r0_r <= r1_r; has1_r <= 1'b0;
          end
          em_any_r <= has1_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_valid) q_addr_r <= q_addr;
  end
endmodule

FILE: rtl/core/tracker_session_controller_unit.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  kind, tracker, now_ms, packet_type, first_byte,
//                                          signature_found, remote_addr
// out_     output     out_valid/out_stall  action, out_tracker, packet_number,
//                                          reset_socket, to_broadcast, server_known, last
// cfg_     input      cfg_we               cfg_index, cfg_data (20 bits)
//
// In the back end an event is taken, executed and then emitted one result at a time; the
// execute step is a read-modify-write of the slot's state. A two-entry queue separates
// classification from execution, so input transfers go on while a result is stalled until
// the queue is full. Reset is synchronous and active low; all session state clears.
module tracker_session_controller_unit #(
  parameter int NUM_TRACKERS = 16,
  parameter int TIME_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_tracker,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_packet_type,
  input  logic [7:0]  in_first_byte,
  input  logic        in_signature_found,
  input  logic [31:0] in_remote_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [3:0]  out_out_tracker,
  output logic [31:0] out_packet_number,
  output logic        out_reset_socket,
  output logic        out_to_broadcast,
  output logic        out_server_known,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import tsc_pkg::*;

  logic [19:0] cooldown_r, timeout_r, heartbeat_r, retry_r;
  logic [7:0]  stagger_r;
  logic [3:0]  period_r, hub_r;

  // Configuration registers: one write per transfer, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooldown_r <= 20'd30000; timeout_r <= 20'd5000; heartbeat_r <= 20'd900;
      retry_r <= 20'd1000; stagger_r <= 8'd20; period_r <= 4'd10; hub_r <= 4'd15;
    end else if (cfg_we) begin
      case (cfg_index)
        3'(REG_COOLDOWN):  cooldown_r  <= cfg_data;
        3'(REG_TIMEOUT):   timeout_r   <= cfg_data;
        3'(REG_HEARTBEAT): heartbeat_r <= cfg_data;
        3'(REG_RETRY):     retry_r     <= cfg_data;
        3'(REG_STAGGER):   stagger_r   <= cfg_data[7:0];
        3'(REG_PERIOD):    period_r    <= cfg_data[3:0];
        3'(REG_HUB):       hub_r       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic        q_valid, q_take;
  evt_t        q_evt;
  logic [31:0] q_addr;
  res_t        res;

  tsc_front #(.NUM_TRACKERS(NUM_TRACKERS), .QDEPTH(2)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_tracker, .in_now_ms,
    .in_packet_type, .in_first_byte, .in_signature_found, .in_remote_addr,
    .q_valid, .q_evt, .q_addr, .q_take
  );

  tsc_back #(.NUM_TRACKERS(NUM_TRACKERS), .TIME_BITS(TIME_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_evt, .q_addr, .q_take,
    .cooldown_ms(cooldown_r), .timeout_ms(timeout_r), .heartbeat_ms(heartbeat_r),
    .retry_base_ms(retry_r), .retry_stagger_ms(stagger_r),
    .socket_reset_period(period_r), .hub_index(hub_r),
    .out_valid, .out_stall, .out_res(res)
  );

  assign out_action        = res.action;
  assign out_out_tracker   = res.tracker;
  assign out_packet_number = res.packet_number;
  assign out_reset_socket  = res.reset_socket;
  assign out_to_broadcast  = res.to_broadcast;
  assign out_server_known  = res.server_known;
  assign out_last          = res.last;

`ifndef SYNTHESIS
  // A stalled result must hold until it is transferred.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_packet_number))
    else $error("stalled result changed");
  // Echo results never consume a sequence number.
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_ECHO |-> out_packet_number == 32'd0)
    else $error("echo with packet number");
  // Only handshakes carry a socket reset.
  a_rst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reset_socket |-> out_action == ACT_HANDSHAKE)
    else $error("socket reset on non-handshake");
`endif

endmodule

FILE: tb/tracker_session_controller_unit_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the tracker session controller. A directed table is
// walked first, then random session traffic is sent under several register settings.
module tracker_session_controller_unit_tb;
  import tsc_pkg::*;

  localparam int NUM_SLOTS  = 16;
  localparam int WATCH_MAX  = 5000;
  localparam int DRAIN_WAIT = 12;
  localparam int PER_PHASE  = 130;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_kind;
  logic [3:0]  in_tracker;
  logic [31:0] in_now_ms;
  logic [31:0] in_packet_type;
  logic [7:0]  in_first_byte;
  logic        in_signature_found;
  logic [31:0] in_remote_addr;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_action;
  logic [3:0]  out_out_tracker;
  logic [31:0] out_packet_number;
  logic        out_reset_socket;
  logic        out_to_broadcast;
  logic        out_server_known;
  logic        out_last;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;

  tracker_session_controller_unit uut (.*);

  // One row of stimulus. A negative typed_n means the predictor supplies the
  // expected sends; otherwise typed_n sends (zero or one) are typed in here.
  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  trk;
    logic [31:0] now;
    logic [31:0] ptype;
    logic [7:0]  fbyte;
    logic        sig;
    logic [31:0] raddr;
    int          typed_n;
    res_t        typed;
  } event_row_t;

  // Shadow copy of the session state and the registers.
  logic [19:0] cooldown_r, timeout_r, heartbeat_r, retry_r;
  logic [7:0]  stagger_r;
  logic [3:0]  period_r, hub_r;
  logic        active_s [NUM_SLOTS];
  logic        hshake_s [NUM_SLOTS];
  logic        init_s   [NUM_SLOTS];
  logic [31:0] hs_time  [NUM_SLOTS];
  logic [31:0] rx_time  [NUM_SLOTS];
  logic [31:0] hb_time  [NUM_SLOTS];
  logic [31:0] to_time  [NUM_SLOTS];
  logic [3:0]  phase_s  [NUM_SLOTS];
  logic [31:0] seq_s    [NUM_SLOTS];
  logic        discovery_s, known_s;
  logic [31:0] server_s;

  res_t        sends_q[$];
  event_row_t  table_rows[$];
  int          errors;
  int          events_sent;
  int          sends_seen;
  logic        quiet;
  logic        holdoff_done;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic session_reset();
    cooldown_r = 20'd30000; timeout_r = 20'd5000; heartbeat_r = 20'd900;
    retry_r = 20'd1000; stagger_r = 8'd20; period_r = 4'd10; hub_r = 4'd15;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      active_s[i] = 1'b0; hshake_s[i] = 1'b0; init_s[i] = 1'b0;
      hs_time[i] = '0; rx_time[i] = '0; hb_time[i] = '0; to_time[i] = '0;
      phase_s[i] = '0; seq_s[i] = '0;
    end
    discovery_s = 1'b1; known_s = 1'b0; server_s = '0;
  endtask

  // Queue one expected send; the sequence number is consumed unless it is an echo.
  task automatic queue_send(action_t act, logic [3:0] t, logic rst, logic bcast);
    res_t r;
    r.action = act;
    r.tracker = t;
    r.packet_number = (act == ACT_ECHO) ? 32'd0 : seq_s[t];
    if (act != ACT_ECHO) seq_s[t] = seq_s[t] + 32'd1;
    r.reset_socket = rst;
    r.to_broadcast = bcast;
    r.server_known = known_s;
    r.last = 1'b0;
    sends_q.push_back(r);
  endtask

  // Works out what one accepted event sends and updates the shadow state.
  task automatic predict_session_event(event_row_t e);
    int   queued_n;
    logic rst;
    logic [31:0] interval;
    res_t r;
    queued_n = sends_q.size();
    case (e.kind)
      KIND_LINK_UP: begin
        known_s = 1'b0; discovery_s = 1'b1; server_s = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (i == hub_r) active_s[i] = 1'b1;
          if (active_s[i]) begin
            rx_time[i] = e.now; hb_time[i] = e.now; phase_s[i] = '0;
            init_s[i] = 1'b0; hshake_s[i] = 1'b1; hs_time[i] = '0; seq_s[i] = '0;
          end
        end
      end
      KIND_LINK_DOWN: begin
        discovery_s = 1'b1; known_s = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          init_s[i] = 1'b0; hshake_s[i] = 1'b0;
        end
      end
      KIND_ACTIVATE: begin
        if (!active_s[e.trk]) begin
          active_s[e.trk] = 1'b1; seq_s[e.trk] = '0; hshake_s[e.trk] = 1'b1;
          init_s[e.trk] = 1'b0; hb_time[e.trk] = e.now; hs_time[e.trk] = e.now;
          queue_send(ACT_HANDSHAKE, e.trk, 1'b0, discovery_s);
        end
      end
      KIND_TICK: begin
        if (active_s[e.trk]) begin
          // While the cooldown after a timeout runs, the tick leaves the slot alone.
          if (!(hshake_s[e.trk] && to_time[e.trk] != 0 &&
                (e.now - to_time[e.trk]) < {12'd0, cooldown_r})) begin
            if (hshake_s[e.trk]) begin
              interval = {12'd0, retry_r} + e.trk * stagger_r;
              if ((e.now - hs_time[e.trk]) > interval) begin
                hs_time[e.trk] = e.now;
                phase_s[e.trk] = phase_s[e.trk] + 4'd1;
                rst = 1'b0;
                if (phase_s[e.trk] >= period_r) begin
                  phase_s[e.trk] = '0;
                  rst = 1'b1;
                end
                queue_send(ACT_HANDSHAKE, e.trk, rst, discovery_s);
              end
            end
            if (init_s[e.trk] && (e.now - rx_time[e.trk]) > {12'd0, timeout_r}) begin
              init_s[e.trk] = 1'b0; hshake_s[e.trk] = 1'b1; phase_s[e.trk] = '0;
              hs_time[e.trk] = '0; to_time[e.trk] = e.now;
            end
            if (init_s[e.trk] && e.trk != hub_r &&
                (e.now - hb_time[e.trk]) > {12'd0, heartbeat_r}) begin
              hb_time[e.trk] = e.now;
              queue_send(ACT_HEARTBEAT, e.trk, 1'b0, 1'b0);
            end
          end
        end
      end
      KIND_PACKET: begin
        if (active_s[e.trk]) begin
          if (discovery_s) begin
            server_s = e.raddr; discovery_s = 1'b0; known_s = 1'b1;
          end
          rx_time[e.trk] = e.now;
          if (e.ptype == PTYPE_ECHO) begin
            queue_send(ACT_ECHO, e.trk, 1'b0, 1'b0);
          end else if (e.ptype == PTYPE_HEARTBEAT) begin
            queue_send(ACT_HEARTBEAT, e.trk, 1'b0, 1'b0);
          end else if ((e.ptype == PTYPE_HANDSHAKE || e.fbyte == FBYTE_HANDSHAKE) &&
                       e.sig && hshake_s[e.trk]) begin
            hshake_s[e.trk] = 1'b0; init_s[e.trk] = 1'b1; to_time[e.trk] = '0;
            if (e.trk == hub_r) begin
              known_s = 1'b1; active_s[e.trk] = 1'b0;
            end else begin
              queue_send(ACT_HANDSHAKE, e.trk, 1'b0, discovery_s);
              queue_send(ACT_SENSOR, e.trk, 1'b0, 1'b0);
            end
          end
        end
      end
      default: ;
    endcase
    if (sends_q.size() > queued_n) begin
      r = sends_q.pop_back();
      r.last = 1'b1;
      sends_q.push_back(r);
    end
  endtask

  // Offers one event, with a random gap first unless the run is quiet, and records its
  // expected sends once the transfer has taken place.
  task automatic offer_event(event_row_t e);
    int queued_n;
    if (!quiet) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_kind <= e.kind;
    in_tracker <= e.trk;
    in_now_ms <= e.now;
    in_packet_type <= e.ptype;
    in_first_byte <= e.fbyte;
    in_signature_found <= e.sig;
    in_remote_addr <= e.raddr;
    do @(posedge clk); while (in_stall);
    events_sent++;
    queued_n = sends_q.size();
    predict_session_event(e);
    if (e.typed_n >= 0) begin
      // The typed row replaces whatever the predictor queued for this event.
      while (sends_q.size() > queued_n) void'(sends_q.pop_back());
      if (e.typed_n > 0) sends_q.push_back(e.typed);
    end
  endtask

  // Register writes happen only with the block drained and quiet.
  task automatic write_settings(logic [19:0] v [7]);
    in_valid <= 1'b0;
    while (sends_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      @(posedge clk);
      case (reg_idx_t'(i))
        REG_COOLDOWN:  cooldown_r = v[i];
        REG_TIMEOUT:   timeout_r = v[i];
        REG_HEARTBEAT: heartbeat_r = v[i];
        REG_RETRY:     retry_r = v[i];
        REG_STAGGER:   stagger_r = v[i][7:0];
        REG_PERIOD:    period_r = v[i][3:0];
        default:       hub_r = v[i][3:0];
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  function automatic event_row_t make_row(kind_t k, logic [3:0] t, logic [31:0] now,
                                          logic [31:0] pt, logic [7:0] fb, logic sg,
                                          int tn);
    event_row_t e;
    e.kind = k; e.trk = t; e.now = now; e.ptype = pt; e.fbyte = fb; e.sig = sg;
    e.raddr = $urandom();
    e.typed_n = tn;
    e.typed = '0;
    return e;
  endfunction

  // Random events: mostly well-formed session traffic on a clock that advances,
  // with some raw noise on every field.
  function automatic event_row_t random_event();
    event_row_t e;
    int pick;
    pick = $urandom_range(99);
    if ($urandom_range(49) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, 1600);
    e.now = clock_ms;
    e.trk = (pick < 70) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(0, 15));
    e.ptype = '0;
    e.fbyte = 8'($urandom_range(0, 255));
    e.sig = ($urandom_range(3) != 0);
    e.raddr = $urandom();
    e.typed_n = -1;
    e.typed = '0;
    pick = $urandom_range(99);
    if (pick < 10) e.kind = KIND_ACTIVATE;
    else if (pick < 55) e.kind = KIND_TICK;
    else if (pick < 90) e.kind = KIND_PACKET;
    else if (pick < 94) e.kind = KIND_LINK_UP;
    else if (pick < 97) e.kind = KIND_LINK_DOWN;
    else e.kind = 3'($urandom_range(5, 7));
    case ($urandom_range(5))
      0: e.ptype = PTYPE_ECHO;
      1: e.ptype = PTYPE_HEARTBEAT;
      2: e.ptype = PTYPE_HANDSHAKE;
      3: begin e.ptype = $urandom(); e.fbyte = FBYTE_HANDSHAKE; end
      default: e.ptype = $urandom();
    endcase
    return e;
  endfunction

  // Result side: every transfer is compared with the oldest expected send.
  always @(posedge clk) begin
    res_t w;
    if (rst_n && out_valid && !out_stall) begin
      sends_seen++;
      if (sends_q.size() == 0) begin
        $display("%0t: unexpected send, got action %0d slot %0d", $time,
                 out_action, out_out_tracker);
        errors++;
      end else begin
        w = sends_q.pop_front();
        if (out_action !== w.action) begin
          $display("%0t: action expected %0d got %0d", $time, w.action, out_action);
          errors++;
        end
        if (out_out_tracker !== w.tracker) begin
          $display("%0t: slot expected %0d got %0d", $time, w.tracker, out_out_tracker);
          errors++;
        end
        if (out_packet_number !== w.packet_number) begin
          $display("%0t: packet number expected %0d got %0d", $time, w.packet_number,
                   out_packet_number);
          errors++;
        end
        if (out_reset_socket !== w.reset_socket) begin
          $display("%0t: reset_socket expected %0b got %0b", $time, w.reset_socket,
                   out_reset_socket);
          errors++;
        end
        if (out_to_broadcast !== w.to_broadcast) begin
          $display("%0t: to_broadcast expected %0b got %0b", $time, w.to_broadcast,
                   out_to_broadcast);
          errors++;
        end
        if (out_server_known !== w.server_known) begin
          $display("%0t: server_known expected %0b got %0b", $time, w.server_known,
                   out_server_known);
          errors++;
        end
        if (out_last !== w.last) begin
          $display("%0t: last expected %0b got %0b", $time, w.last, out_last);
          errors++;
        end
      end
    end
  end

  // Receiver stalls at random, with one long hold-off once the run is well under way
  // so that the block's queue fills and it stalls its input.
  initial begin
    out_stall = 1'b0;
    holdoff_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!holdoff_done && events_sent >= 250) begin
        holdoff_done = 1'b1;
        for (int c = 0; c < 300; c++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 18);
    end
  end

  // Watchdog: too many cycles without any transfer on either channel ends the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_MAX) begin
        $display("Watchdog expired at %0t with %0d sends outstanding", $time,
                 sends_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [19:0] regs [7];
    event_row_t  e;
    res_t        first_hs;
    errors = 0; events_sent = 0; sends_seen = 0; quiet = 1'b0; clock_ms = 32'd0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_kind = '0; in_tracker = '0; in_now_ms = '0;
    in_packet_type = '0; in_first_byte = '0; in_signature_found = 1'b0;
    in_remote_addr = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    session_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first activate after reset broadcasts handshake number zero.
    first_hs = '{action: ACT_HANDSHAKE, tracker: 4'd0, packet_number: 32'd0,
                 reset_socket: 1'b0, to_broadcast: 1'b1, server_known: 1'b0, last: 1'b1};
    e = make_row(KIND_ACTIVATE, 4'd0, 32'd100, '0, '0, 1'b0, 1);
    e.typed = first_hs;
    table_rows.push_back(e);
    // A second activate, unknown kinds and events on an idle slot send nothing.
    table_rows.push_back(make_row(KIND_ACTIVATE, 4'd0, 32'd150, '0, '0, 1'b0, 0));
    table_rows.push_back(make_row(kind_t'(3'd5), 4'd3, 32'd160, '1, '1, 1'b1, 0));
    table_rows.push_back(make_row(kind_t'(3'd7), 4'd15, '1, '1, '1, 1'b1, 0));
    table_rows.push_back(make_row(KIND_TICK, 4'd1, 32'd5000, '0, '0, 1'b0, 0));
    table_rows.push_back(make_row(KIND_PACKET, 4'd1, 32'd5000, 32'd3, 8'd3, 1'b1, 0));
    // Retry, echo, heartbeat request and handshake reply on slot zero.
    table_rows.push_back(make_row(KIND_TICK, 4'd0, 32'd2000, '0, '0, 1'b0, -1));
    table_rows.push_back(make_row(KIND_PACKET, 4'd0, 32'd2100, PTYPE_ECHO, 8'd0, 1'b0, -1));
    table_rows.push_back(make_row(KIND_PACKET, 4'd0, 32'd2100, PTYPE_HEARTBEAT, 8'd0,
                                  1'b0, -1));
    table_rows.push_back(make_row(KIND_PACKET, 4'd0, 32'd2200, 32'd0, FBYTE_HANDSHAKE,
                                  1'b1, -1));
    table_rows.push_back(make_row(KIND_TICK, 4'd0, 32'd3100, '0, '0, 1'b0, -1));
    // Silence drops the session, then the cooldown holds back handshakes.
    table_rows.push_back(make_row(KIND_TICK, 4'd0, 32'd9000, '0, '0, 1'b0, -1));
    table_rows.push_back(make_row(KIND_TICK, 4'd0, 32'd9500, '0, '0, 1'b0, 0));
    // Link up arms the hub; the hub reply sends nothing and retires the hub.
    table_rows.push_back(make_row(KIND_LINK_UP, 4'd0, 32'd0, '0, '0, 1'b0, 0));
    table_rows.push_back(make_row(KIND_PACKET, 4'd15, 32'd10, PTYPE_HANDSHAKE, 8'd0,
                                  1'b1, -1));
    table_rows.push_back(make_row(KIND_ACTIVATE, 4'd15, 32'd20, '0, '0, 1'b0, -1));
    table_rows.push_back(make_row(KIND_LINK_DOWN, 4'd2, 32'd30, '0, '0, 1'b0, 0));
    // A reply on a slot that is not handshaking sends nothing; it refreshes its receive time and ends discovery.
    table_rows.push_back(make_row(KIND_PACKET, 4'd0, 32'd40, '1, FBYTE_HANDSHAKE, 1'b1, -1));
    table_rows.push_back(make_row(KIND_TICK, 4'd0, '1, '0, '0, 1'b0, -1));
    table_rows.push_back(make_row(KIND_ACTIVATE, 4'd7, 32'h8000_0000, '0, '0, 1'b0, -1));
    table_rows.push_back(make_row(KIND_TICK, 4'd7, 32'h0000_0005, '0, '0, 1'b0, -1));
    foreach (table_rows[i]) offer_event(table_rows[i]);

    // Random phases: defaults, all zero (period zero too), all at maximum, then mixed.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ;
        1: regs = '{20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0};
        2: regs = '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFF, 20'hF, 20'hF};
        default: regs = '{20'($urandom_range(0, 8000)), 20'($urandom_range(500, 6000)),
                          20'($urandom_range(100, 2000)), 20'($urandom_range(200, 1500)),
                          20'($urandom_range(0, 255)), 20'($urandom_range(1, 15)),
                          20'($urandom_range(0, 15))};
      endcase
      if (ph != 0) write_settings(regs);
      for (int n = 0; n < PER_PHASE; n++) begin
        // One stretch of the run with no idling on either side.
        quiet = (ph == 3 && n >= 40 && n < 110);
        offer_event(random_event());
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sends_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d events and %0d sends over five register settings,",
             events_sent, sends_seen);
    $display("including a long result hold-off and a stretch without gaps.");
    if (errors == 0 && sends_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
